// File: hw/rtl/gb5q_pkg.sv
// ----------------------------------------------------------------------------
// gb5q_pkg
// Shared types, constants and lookup tables for the 5x5 blur and quantizer.
// ----------------------------------------------------------------------------
package gb5q_pkg;

    localparam int PIX_W       = 8;
    localparam int CH_N        = 3;
    localparam int LANES       = 4;
    localparam int TAPS        = 5;
    localparam int VSUM_W      = 12;
    localparam int HSUM_W      = 15;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 12;
    localparam int LEVELS_W    = 8;
    localparam int RECIP_W     = 17;
    localparam int RECIP_FRAC  = 16;
    localparam int QPROD_W     = PIX_W + RECIP_W;
    localparam int QUEUE_DEPTH = 2;

    localparam int DEF_MAX_WIDTH  = 2048;
    localparam int DEF_MAX_HEIGHT = 2048;
    localparam int RESET_WIDTH    = 640;
    localparam int RESET_HEIGHT   = 480;

    localparam int DIV100_W     = 16;
    localparam int DIV100_MUL   = 41944;
    localparam int DIV100_SHIFT = 22;
    localparam int PROD_W       = HSUM_W + DIV100_W;

    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_QUANT_LEVELS = 2'd2;

    // Channel 0 is blue, 1 is green, 2 is red.
    typedef logic [CH_N-1:0][PIX_W-1:0]  t_pixel;
    typedef logic [CH_N-1:0][VSUM_W-1:0] t_vsum;
    typedef t_pixel [LANES-1:0]          t_lines;

    typedef struct packed {
        logic                interior;
        logic                last;
        t_pixel              border;
        t_vsum [TAPS-1:0]    cols;
    } t_task;

    typedef struct packed {
        logic                enable;
        logic [PIX_W-1:0]    step;
        logic [RECIP_W-1:0]  recip;
    } t_quant;

    function automatic logic [RECIP_W-1:0] f_udiv(input logic [RECIP_W-1:0] num,
                                                  input logic [PIX_W-1:0] den);
        logic [RECIP_W:0]   rem;
        logic [RECIP_W-1:0] quo;
        rem = '0;
        quo = '0;
        for (int i = RECIP_W - 1; i >= 0; i--) begin
            rem = {rem[RECIP_W-1:0], num[i]};
            if (rem >= (RECIP_W + 1)'(den)) begin
                rem    = rem - (RECIP_W + 1)'(den);
                quo[i] = 1'b1;
            end
        end
        return quo;
    endfunction

    function automatic logic [255:0][PIX_W-1:0] f_step_table();
        logic [255:0][PIX_W-1:0] tbl;
        tbl = '0;
        for (int l = 1; l < 256; l++) begin
            tbl[l] = PIX_W'(f_udiv(RECIP_W'(255), PIX_W'(l)));
        end
        return tbl;
    endfunction

    function automatic logic [255:0][RECIP_W-1:0] f_recip_table();
        logic [255:0][PIX_W-1:0]   stp;
        logic [255:0][RECIP_W-1:0] tbl;
        stp = f_step_table();
        tbl = '0;
        for (int l = 1; l < 256; l++) begin
            tbl[l] = f_udiv(RECIP_W'(65536), stp[l]);
        end
        return tbl;
    endfunction

    localparam logic [255:0][PIX_W-1:0]   QSTEP_TABLE  = f_step_table();
    localparam logic [255:0][RECIP_W-1:0] QRECIP_TABLE = f_recip_table();

endpackage

// File: hw/rtl/gb5q_front.sv
// ----------------------------------------------------------------------------
// gb5q_front
// Accepts words, keeps the frame position, the line stores and the column
// sum window, and queues one task for every result.
// ----------------------------------------------------------------------------
module gb5q_front #(
    parameter int MAX_WIDTH  = gb5q_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = gb5q_pkg::DEF_MAX_HEIGHT
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic                                i_kind,
    input  logic [gb5q_pkg::PIX_W-1:0]          i_blue_in,
    input  logic [gb5q_pkg::PIX_W-1:0]          i_green_in,
    input  logic [gb5q_pkg::PIX_W-1:0]          i_red_in,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [gb5q_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [gb5q_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    output logic                                o_push,
    output gb5q_pkg::t_task                     o_task,
    input  logic                                i_full,
    output gb5q_pkg::t_quant                    o_quant
);
    import gb5q_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int HW = $clog2(MAX_HEIGHT + 1);
    localparam int RW = $clog2(MAX_HEIGHT + 5);
    localparam logic [WW-1:0] RST_W =
        WW'((RESET_WIDTH > MAX_WIDTH) ? MAX_WIDTH : RESET_WIDTH);
    localparam logic [HW-1:0] RST_H =
        HW'((RESET_HEIGHT > MAX_HEIGHT) ? MAX_HEIGHT : RESET_HEIGHT);

    localparam logic S_TAKE = 1'b0;
    localparam logic S_WORK = 1'b1;

    logic               r_state;
    logic [WW-1:0]      r_eff_w;
    logic [HW-1:0]      r_eff_h;
    t_quant             r_quant;
    logic [CW-1:0]      r_in_col;
    logic [RW-1:0]      r_in_row;
    logic [CW-1:0]      r_out_col;
    logic [RW-1:0]      r_out_row;
    logic               r_kind;
    t_pixel             r_pix;
    t_lines             r_mem [MAX_WIDTH];
    t_lines             r_rd_win;
    t_lines             r_rd_bdr;
    t_vsum [TAPS-1:0]   r_vcol;

    logic               w_take;
    logic               w_cfg_we;
    logic               w_emit;
    logic               w_interior;
    logic               w_last;
    logic               w_step;
    logic               w_row_in;
    t_pixel             n_pix;
    t_vsum              n_vcol;
    t_vsum [TAPS-1:0]   n_window;
    logic [3:0][1:0]    w_lane;
    logic [WW-1:0]      n_w_clamp;
    logic [HW-1:0]      n_h_clamp;

    assign w_take      = (r_state == S_TAKE) && i_in_valid;
    assign w_cfg_we    = i_cfg_valid && o_cfg_ready;
    assign o_in_stall  = (r_state != S_TAKE);
    assign o_cfg_ready = (r_state == S_TAKE);
    assign o_quant     = r_quant;

    always_comb begin
        n_w_clamp = WW'(i_cfg_data);
        if (i_cfg_data == '0) begin
            n_w_clamp = WW'(1);
        end else if (32'(i_cfg_data) > 32'(MAX_WIDTH)) begin
            n_w_clamp = WW'(MAX_WIDTH);
        end
        n_h_clamp = HW'(i_cfg_data);
        if (i_cfg_data == '0) begin
            n_h_clamp = HW'(1);
        end else if (32'(i_cfg_data) > 32'(MAX_HEIGHT)) begin
            n_h_clamp = HW'(MAX_HEIGHT);
        end
    end

    always_comb begin
        w_row_in = (r_in_row < RW'(r_eff_h));
        n_pix    = r_pix;
        if (r_kind || !w_row_in) begin
            n_pix = '0;
        end
        w_emit = (r_in_row >= RW'(4))
              || ((r_in_row == RW'(3)) && (r_eff_w >= WW'(2)))
              || ((r_in_row == RW'(2)) && (r_in_col >= CW'(2)));
        w_interior = (r_out_row >= RW'(2))
                  && ((RW + 1)'(r_out_row) + (RW + 1)'(3) <= (RW + 1)'(r_eff_h))
                  && (r_out_col >= CW'(2))
                  && ((WW + 1)'(r_out_col) + (WW + 1)'(3) <= (WW + 1)'(r_eff_w));
        w_last = ((RW + 1)'(r_out_row) + (RW + 1)'(1) == (RW + 1)'(r_eff_h))
              && (WW'(r_out_col) + WW'(1) == r_eff_w);
        w_step = (r_state == S_WORK) && (!w_emit || !i_full);
        for (int i = 0; i < 4; i++) begin
            w_lane[i] = r_in_row[1:0] + 2'(i);
        end
        for (int ch = 0; ch < CH_N; ch++) begin
            n_vcol[ch] = VSUM_W'(r_rd_win[w_lane[0]][ch])
                       + (VSUM_W'(r_rd_win[w_lane[1]][ch]) << 1)
                       + (VSUM_W'(r_rd_win[w_lane[2]][ch]) << 2)
                       + (VSUM_W'(r_rd_win[w_lane[3]][ch]) << 1)
                       + VSUM_W'(n_pix[ch]);
        end
        for (int j = 0; j < TAPS - 1; j++) begin
            n_window[j] = r_vcol[j + 1];
        end
        n_window[TAPS-1] = n_vcol;
    end

    assign o_push          = w_step && w_emit;
    assign o_task.interior = w_interior;
    assign o_task.last     = w_last;
    assign o_task.border   = r_rd_bdr[r_out_row[1:0]];
    assign o_task.cols     = n_window;

    always_ff @(posedge i_clk) begin
        if (w_step && w_row_in) begin
            r_mem[r_in_col][r_in_row[1:0]] <= n_pix;
        end
        r_rd_win <= r_mem[r_in_col];
        r_rd_bdr <= r_mem[r_out_col];
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_kind   <= i_kind;
            r_pix[0] <= i_blue_in;
            r_pix[1] <= i_green_in;
            r_pix[2] <= i_red_in;
        end
        if (w_step) begin
            r_vcol <= n_window;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_TAKE;
            r_eff_w   <= RST_W;
            r_eff_h   <= RST_H;
            r_quant   <= '0;
            r_in_col  <= '0;
            r_in_row  <= '0;
            r_out_col <= '0;
            r_out_row <= '0;
        end else begin
            if (w_take) begin
                r_state <= S_WORK;
            end
            if (w_step) begin
                r_state <= S_TAKE;
                if (w_emit && w_last) begin
                    r_in_col  <= '0;
                    r_in_row  <= '0;
                    r_out_col <= '0;
                    r_out_row <= '0;
                end else begin
                    if (WW'(r_in_col) + WW'(1) == r_eff_w) begin
                        r_in_col <= '0;
                        r_in_row <= r_in_row + RW'(1);
                    end else begin
                        r_in_col <= r_in_col + CW'(1);
                    end
                    if (w_emit) begin
                        if (WW'(r_out_col) + WW'(1) == r_eff_w) begin
                            r_out_col <= '0;
                            r_out_row <= r_out_row + RW'(1);
                        end else begin
                            r_out_col <= r_out_col + CW'(1);
                        end
                    end
                end
            end
            if (w_cfg_we) begin
                case (i_cfg_index)
                    CFG_FRAME_WIDTH: begin
                        r_eff_w   <= n_w_clamp;
                        r_in_col  <= '0;
                        r_in_row  <= '0;
                        r_out_col <= '0;
                        r_out_row <= '0;
                    end
                    CFG_FRAME_HEIGHT: begin
                        r_eff_h   <= n_h_clamp;
                        r_in_col  <= '0;
                        r_in_row  <= '0;
                        r_out_col <= '0;
                        r_out_row <= '0;
                    end
                    CFG_QUANT_LEVELS: begin
                        r_quant.enable <= (i_cfg_data[LEVELS_W-1:0] != '0);
                        r_quant.step   <= QSTEP_TABLE[i_cfg_data[LEVELS_W-1:0]];
                        r_quant.recip  <= QRECIP_TABLE[i_cfg_data[LEVELS_W-1:0]];
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

`ifndef SYNTHESIS
    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |-> !i_full)
        else $error("Task pushed into a full queue.");
    a_in_col_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        WW'(r_in_col) < r_eff_w)
        else $error("Input column is outside the frame width.");
    a_out_row_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_row < RW'(r_eff_h))
        else $error("Output row is outside the frame height.");
    a_take_to_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_take |=> (r_state == S_WORK))
        else $error("Accepted word was not processed.");
`endif

endmodule

// File: hw/rtl/gb5q_queue.sv
// ----------------------------------------------------------------------------
// gb5q_queue
// Short task queue between the front and the filter pipeline.
// ----------------------------------------------------------------------------
module gb5q_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  gb5q_pkg::t_task   i_task,
    output logic              o_full,
    input  logic              i_pop,
    output logic              o_empty,
    output gb5q_pkg::t_task   o_task
);
    import gb5q_pkg::*;

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int NW = $clog2(QUEUE_DEPTH + 1);

    t_task          r_slot [QUEUE_DEPTH];
    logic [PW-1:0]  r_wr_ptr;
    logic [PW-1:0]  r_rd_ptr;
    logic [NW-1:0]  r_count;
    logic           w_do_push;
    logic           w_do_pop;

    assign o_full    = (r_count == NW'(QUEUE_DEPTH));
    assign o_empty   = (r_count == '0);
    assign o_task    = r_slot[r_rd_ptr];
    assign w_do_push = i_push && !o_full;
    assign w_do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_slot[r_wr_ptr] <= i_task;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_do_push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + PW'(1);
            end
            if (w_do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + PW'(1);
            end
            if (w_do_push && !w_do_pop) begin
                r_count <= r_count + NW'(1);
            end else if (w_do_pop && !w_do_push) begin
                r_count <= r_count - NW'(1);
            end
        end
    end

endmodule

// File: hw/rtl/gb5q_back.sv
// ----------------------------------------------------------------------------
// gb5q_back
// Five-stage pipeline: horizontal sum, divide by 100, border select and
// quantize, with a registered output word.
// ----------------------------------------------------------------------------
module gb5q_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  gb5q_pkg::t_task               i_task,
    input  logic                          i_empty,
    output logic                          o_pop,
    input  gb5q_pkg::t_quant              i_quant,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [gb5q_pkg::PIX_W-1:0]    o_blue_out,
    output logic [gb5q_pkg::PIX_W-1:0]    o_green_out,
    output logic [gb5q_pkg::PIX_W-1:0]    o_red_out,
    output logic                          o_last_of_frame
);
    import gb5q_pkg::*;

    logic                            w_en;
    logic                            r_v1, r_v2, r_v3, r_v4, r_v5;
    logic                            r_int1, r_int2;
    logic                            r_last1, r_last2, r_last3, r_last4, r_last5;
    t_pixel                          r_bdr1, r_bdr2;
    logic [CH_N-1:0][HSUM_W-1:0]     r_hsum;
    logic [CH_N-1:0][PROD_W-1:0]     r_prod;
    logic [CH_N-1:0][QPROD_W-1:0]    r_qprod;
    t_pixel                          r_val3, r_val4, r_m4, r_res;
    t_pixel                          n_val;
    logic [CH_N-1:0][PIX_W:0]        w_rem;

    assign w_en  = !r_v5 || !i_out_stall;
    assign o_pop = w_en && !i_empty;

    always_comb begin
        for (int ch = 0; ch < CH_N; ch++) begin
            n_val[ch] = r_int2 ? r_prod[ch][DIV100_SHIFT +: PIX_W] : r_bdr2[ch];
            w_rem[ch] = {1'b0, r_val4[ch]} - {1'b0, r_m4[ch]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_int1  <= i_task.interior;
            r_last1 <= i_task.last;
            r_bdr1  <= i_task.border;
            r_int2  <= r_int1;
            r_last2 <= r_last1;
            r_bdr2  <= r_bdr1;
            r_last3 <= r_last2;
            r_val3  <= n_val;
            r_last4 <= r_last3;
            r_val4  <= r_val3;
            r_last5 <= r_last4;
            for (int ch = 0; ch < CH_N; ch++) begin
                r_hsum[ch] <= HSUM_W'(i_task.cols[0][ch])
                            + (HSUM_W'(i_task.cols[1][ch]) << 1)
                            + (HSUM_W'(i_task.cols[2][ch]) << 2)
                            + (HSUM_W'(i_task.cols[3][ch]) << 1)
                            + HSUM_W'(i_task.cols[4][ch]);
                r_prod[ch]  <= PROD_W'(r_hsum[ch]) * PROD_W'(DIV100_MUL);
                r_qprod[ch] <= QPROD_W'(n_val[ch]) * QPROD_W'(i_quant.recip);
                r_m4[ch]    <= PIX_W'((2 * PIX_W)'(r_qprod[ch][RECIP_FRAC +: PIX_W])
                                      * (2 * PIX_W)'(i_quant.step));
                if (!i_quant.enable) begin
                    r_res[ch] <= r_val4[ch];
                end else if (w_rem[ch] >= (PIX_W + 1)'(i_quant.step)) begin
                    r_res[ch] <= r_m4[ch] + i_quant.step;
                end else begin
                    r_res[ch] <= r_m4[ch];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else if (w_en) begin
            r_v1 <= !i_empty;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_v5 <= r_v4;
        end
    end

    assign o_out_valid     = r_v5;
    assign o_blue_out      = r_res[0];
    assign o_green_out     = r_res[1];
    assign o_red_out       = r_res[2];
    assign o_last_of_frame = r_last5;

endmodule

// File: hw/rtl/gaussian_blur_5x5_quantize.sv
// ----------------------------------------------------------------------------
// gaussian_blur_5x5_quantize
// Streaming 5x5 Gaussian blur of BGR pixels with optional quantization.
// ----------------------------------------------------------------------------
// No word is taken until the last is processed: the line store is read in
// the cycle a word is taken and written when it is processed, held while
// the queue is full; that read-then-write on the single line store holds
// the input. Results leave a five-stage pipeline behind a two-entry task
// queue, so the first result of a frame appears 2*width+2 words after the
// first pixel, and drain words push out the last rows. Frame size changes
// restart the frame; the line store needs no clearing after reset.
module gaussian_blur_5x5_quantize #(
    parameter int MAX_WIDTH  = gb5q_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = gb5q_pkg::DEF_MAX_HEIGHT
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic                              i_kind,
    input  logic [gb5q_pkg::PIX_W-1:0]        i_blue_in,
    input  logic [gb5q_pkg::PIX_W-1:0]        i_green_in,
    input  logic [gb5q_pkg::PIX_W-1:0]        i_red_in,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [gb5q_pkg::PIX_W-1:0]        o_blue_out,
    output logic [gb5q_pkg::PIX_W-1:0]        o_green_out,
    output logic [gb5q_pkg::PIX_W-1:0]        o_red_out,
    output logic                              o_last_of_frame,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [gb5q_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [gb5q_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import gb5q_pkg::*;

    logic    w_push;
    logic    w_full;
    logic    w_pop;
    logic    w_empty;
    t_task   w_task_in;
    t_task   w_task_out;
    t_quant  w_quant;

    gb5q_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_kind      (i_kind),
        .i_blue_in   (i_blue_in),
        .i_green_in  (i_green_in),
        .i_red_in    (i_red_in),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_push      (w_push),
        .o_task      (w_task_in),
        .i_full      (w_full),
        .o_quant     (w_quant)
    );

    gb5q_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_task  (w_task_in),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_empty (w_empty),
        .o_task  (w_task_out)
    );

    gb5q_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_task          (w_task_out),
        .i_empty         (w_empty),
        .o_pop           (w_pop),
        .i_quant         (w_quant),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_blue_out      (o_blue_out),
        .o_green_out     (o_green_out),
        .o_red_out       (o_red_out),
        .o_last_of_frame (o_last_of_frame)
    );

endmodule
